FILE: hdl/sktab_pkg.sv
// Shared types and codes for the sorted key table.
package sktab_pkg;

   localparam int KEY_W   = 32;
   localparam int QUOTA_W = 16;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_SEARCH = 2'd2,
      OP_EDIT   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE    = 2'd0,
      STAT_PRESENT = 2'd1,
      STAT_MISSING = 2'd2,
      STAT_FULL    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [QUOTA_W-1:0] quota;
   } entry_type;

endpackage

FILE: hdl/sorted_key_table.sv
// Sorted key table: DEPTH key/quota entries held in ascending key order in one memory.
//
// Request channel (req_valid / req_stall): op, key and quota_in. Ops are insert,
// delete, search and edit quota. Each transaction yields exactly one response
// transaction (rsp_valid / rsp_stall) with status, quota_out and entry_count.
//
// Operation: one request at a time. The scan reads one entry per cycle from the
// memory (registered read) until it meets the first key >= the request key or
// the end of the occupied entries. An insert then moves entries up one slot,
// one per cycle; a delete moves them down. Search, edit and all rejected
// requests skip the move. The response follows the last memory step; the single
// memory port pair sets how long an item takes.
//
// Reset clears the entry count and the control state only; the memory needs
// no clearing since positions at or above the count are never used.
// While rsp_stall is high the response holds and req_stall stays high; a new
// request is taken in the same cycle that the pending response leaves.
module sorted_key_table
   import sktab_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_op,
   input  logic [KEY_W-1:0]    req_key,
   input  logic [QUOTA_W-1:0]  req_quota_in,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [1:0]          rsp_status,
   output logic [QUOTA_W-1:0]  rsp_quota_out,
   output logic [4:0]          rsp_entry_count
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   entry_type entry_mem [DEPTH];
   entry_type rd_data_ff;

   state_type          state_ff,  state_in;
   op_type             op_ff,     op_in;
   logic [KEY_W-1:0]   key_ff,    key_in;
   logic [QUOTA_W-1:0] quota_ff,  quota_in;
   logic [CW-1:0]      pos_ff,    pos_in;
   logic [CW-1:0]      sh_ff,     sh_in;
   logic [CW-1:0]      count_ff,  count_in;
   status_type         status_ff, status_in;
   logic [QUOTA_W-1:0] qout_ff,   qout_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr;
   entry_type     wr_data;
   logic [AW-1:0] rd_addr;

   logic [CW-1:0] pos_nxt;
   logic [CW-1:0] sh_nxt;
   logic [CW-1:0] sh_dec;
   logic [CW-1:0] sh_dec2;
   logic [CW-1:0] sh_inc2;
   logic [CW-1:0] count_dec;
   logic          scan_end;
   logic          hit;
   logic          full;

   assign pos_nxt   = pos_ff + CW'(1);
   assign sh_nxt    = sh_ff + CW'(1);
   assign sh_dec    = sh_ff - CW'(1);
   assign sh_dec2   = sh_ff - CW'(2);
   assign sh_inc2   = sh_ff + CW'(2);
   assign count_dec = count_ff - CW'(1);
   assign full      = (count_ff == CW'(DEPTH));

   // rd_data_ff holds the entry at pos_ff during the scan
   assign scan_end = (pos_ff == count_ff) || (rd_data_ff.key >= key_ff);
   assign hit      = (pos_ff != count_ff) && (rd_data_ff.key == key_ff);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= entry_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      op_ff     <= op_in;
      key_ff    <= key_in;
      quota_ff  <= quota_in;
      pos_ff    <= pos_in;
      sh_ff     <= sh_in;
      status_ff <= status_in;
      qout_ff   <= qout_in;
   end

   always_comb begin
      state_in  = state_ff;
      op_in     = op_ff;
      key_in    = key_ff;
      quota_in  = quota_ff;
      pos_in    = pos_ff;
      sh_in     = sh_ff;
      count_in  = count_ff;
      status_in = status_ff;
      qout_in   = qout_ff;
      wr_en     = 1'b0;
      wr_addr   = pos_ff[AW-1:0];
      wr_data   = '{key: key_ff, quota: quota_ff};
      rd_addr   = '0;
      req_stall = 1'b1;
      rsp_valid = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            req_stall = rsp_stall;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!scan_end) begin
               pos_in  = pos_nxt;
               rd_addr = pos_nxt[AW-1:0];
            end else begin
               status_in = STAT_DONE;
               qout_in   = '0;
               state_in  = ST_RESP;
               case (op_ff)
                  OP_SEARCH: begin
                     if (hit) begin
                        qout_in = rd_data_ff.quota;
                     end else begin
                        status_in = STAT_MISSING;
                     end
                  end
                  OP_EDIT: begin
                     if (hit) begin
                        wr_en   = 1'b1;
                        wr_data = '{key: rd_data_ff.key, quota: quota_ff};
                     end else begin
                        status_in = STAT_MISSING;
                     end
                  end
                  OP_INSERT: begin
                     if (hit) begin
                        status_in = STAT_PRESENT;
                     end else if (full) begin
                        status_in = STAT_FULL;
                     end else begin
                        // move entries up from the top, last one first
                        sh_in    = count_ff;
                        rd_addr  = count_dec[AW-1:0];
                        state_in = ST_SHIFT;
                     end
                  end
                  OP_DELETE: begin
                     if (!hit) begin
                        status_in = STAT_MISSING;
                     end else begin
                        sh_in    = pos_ff;
                        rd_addr  = pos_nxt[AW-1:0];
                        state_in = ST_SHIFT;
                     end
                  end
                  default: begin
                     status_in = STAT_MISSING;
                  end
               endcase
            end
         end
         ST_SHIFT: begin
            if (op_ff == OP_INSERT) begin
               wr_en   = 1'b1;
               wr_addr = sh_ff[AW-1:0];
               if (sh_ff == pos_ff) begin
                  count_in = count_ff + CW'(1);
                  state_in = ST_RESP;
               end else begin
                  wr_data = rd_data_ff;
                  rd_addr = sh_dec2[AW-1:0];
                  sh_in   = sh_dec;
               end
            end else begin
               if (sh_nxt == count_ff) begin
                  count_in = count_dec;
                  state_in = ST_RESP;
               end else begin
                  wr_en   = 1'b1;
                  wr_addr = sh_ff[AW-1:0];
                  wr_data = rd_data_ff;
                  rd_addr = sh_inc2[AW-1:0];
                  sh_in   = sh_nxt;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // take a new transaction; the scan starts with entry zero
      if (req_valid && !req_stall) begin
         op_in    = op_type'(req_op);
         key_in   = req_key;
         quota_in = req_quota_in;
         pos_in   = '0;
         rd_addr  = '0;
         state_in = ST_SCAN;
      end
   end

   assign rsp_status      = status_ff;
   assign rsp_quota_out   = qout_ff;
   assign rsp_entry_count = 5'(count_ff);

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above table depth");

   a_full_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && status_ff == STAT_FULL) |-> full)
      else $error("table full reported with free entries");

   a_quota_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (status_ff != STAT_DONE || op_ff != OP_SEARCH)) |-> qout_ff == '0)
      else $error("nonzero quota on a response other than a found search");

   a_count_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_SHIFT) |=> count_ff == $past(count_ff))
      else $error("entry count changed outside a move");

   a_shift_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SHIFT) |-> (sh_ff <= count_ff && sh_ff >= pos_ff))
      else $error("move pointer outside the occupied range");

endmodule
